FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// Depends on nothing; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property at each clock edge, disabled while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property at each clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/dttd_pkg.sv
// Shared types, constants and helper functions of the decimal text to double unit.
// Depends on nothing; the queue, front end, back end and top level import it.
package dttd_pkg;

   localparam int unsigned EXP_SAT     = 1048575;
   localparam int unsigned SCALE_LIMIT = 1100;

   localparam int EXPD_W  = $clog2(EXP_SAT + 1);
   localparam int EXPV_W  = EXPD_W + 5;
   localparam int ESUM_W  = EXPD_W + 2;
   localparam int SCALE_W = $clog2(SCALE_LIMIT + 1) + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // back end datapath widths
   localparam int W_W        = 116;
   localparam int BEXP_W     = 13;
   localparam int PROD_W     = 110;
   localparam int MOP_W      = 56;
   localparam int MULP_ITERS = MOP_W / 4;
   localparam int CNT_W      = $clog2(MULP_ITERS);

   // significand of 0.1 with hidden bit, value = TENTH_M * 2^-56
   localparam logic [52:0] TENTH_M = 53'h1999999999999A;
   localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_E_LO  = 8'h65;
   localparam logic [7:0] CH_E_UP  = 8'h45;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      PH_INT,
      PH_FRAC,
      PH_EXP_SIGN,
      PH_EXP_DIG,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL10,
      BK_ADD,
      BK_SCALE,
      BK_MULP,
      BK_NORM,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic                      has_digit;
      logic                      has_finish;
      logic [3:0]                digit;
      logic signed [SCALE_W-1:0] scale;
   } q_entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

   // exact binary64 encoding of a single digit
   function automatic logic [63:0] digit_to_double(input logic [3:0] d);
      logic [63:0] r;
      case (d)
         4'd1:    r = 64'h3FF0_0000_0000_0000;
         4'd2:    r = 64'h4000_0000_0000_0000;
         4'd3:    r = 64'h4008_0000_0000_0000;
         4'd4:    r = 64'h4010_0000_0000_0000;
         4'd5:    r = 64'h4014_0000_0000_0000;
         4'd6:    r = 64'h4018_0000_0000_0000;
         4'd7:    r = 64'h401C_0000_0000_0000;
         4'd8:    r = 64'h4020_0000_0000_0000;
         4'd9:    r = 64'h4022_0000_0000_0000;
         default: r = 64'h0;
      endcase
      return r;
   endfunction

   // one radix-16 partial product of the 0.1 significand
   function automatic logic [56:0] tenth_multiple(input logic [3:0] d);
      return 57'(TENTH_M) * 57'(d);
   endfunction

endpackage

FILE: rtl/core/dttd_queue.sv
// Short command queue between the character front end and the arithmetic back end.
// Depends on dttd_pkg for the entry and status types.
module dttd_queue import dttd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  q_entry_type  push_entry,
   input  logic         pop,
   output q_status_type status,
   output q_entry_type  head
);

   q_entry_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head         = mem_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/dttd_front.sv
// Character front end: tracks the parse phase and exponents, queues digit and finish work.
// Depends on dttd_pkg for character codes, phases and the queue entry type.
module dttd_front import dttd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_ch,
   input  logic         req_last,
   input  q_status_type q_status,
   output logic         q_push,
   output q_entry_type  q_entry
);

   localparam logic signed [ESUM_W-1:0] ESUM_HI = ESUM_W'(SCALE_LIMIT);
   localparam logic signed [ESUM_W-1:0] ESUM_LO = -ESUM_HI;

   phase_type         phase_ff, phase_in, phase_nx;
   logic [EXPD_W-1:0] dec_ff, dec_in, dec_nx;
   logic [EXPD_W-1:0] exp_ff, exp_in, exp_nx;
   logic              neg_ff, neg_in, neg_nx;

   logic              accept, finish, is_dig, has_ch;
   logic              dig_acc, dec_step, exp_step, neg_set;
   logic [3:0]        dval;
   logic [EXPV_W-1:0] exp_v;
   logic signed [ESUM_W-1:0] esum;
   logic signed [SCALE_W-1:0] scale;

   assign accept = req_valid && !q_status.full;
   assign has_ch = (req_ch != CH_NUL);
   assign finish = accept && (!has_ch || req_last);
   assign is_dig = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
   assign dval   = req_ch[3:0];

   // next phase
   always_comb begin
      phase_nx = phase_ff;
      if (has_ch) begin
         case (phase_ff)
            PH_INT: begin
               if (is_dig) phase_nx = PH_INT;
               else if (req_ch == CH_DOT) phase_nx = PH_FRAC;
               else if (req_ch == CH_E_LO || req_ch == CH_E_UP) phase_nx = PH_EXP_SIGN;
               else phase_nx = PH_DONE;
            end
            PH_FRAC: begin
               if (is_dig) phase_nx = PH_FRAC;
               else if (req_ch == CH_E_LO || req_ch == CH_E_UP) phase_nx = PH_EXP_SIGN;
               else phase_nx = PH_DONE;
            end
            PH_EXP_SIGN: begin
               if (req_ch == CH_PLUS || req_ch == CH_MINUS || is_dig) phase_nx = PH_EXP_DIG;
               else phase_nx = PH_DONE;
            end
            PH_EXP_DIG: begin
               if (!is_dig) phase_nx = PH_DONE;
            end
            default: phase_nx = phase_ff;
         endcase
      end
      if (!accept) phase_in = phase_ff;
      else if (finish) phase_in = PH_INT;
      else phase_in = phase_nx;
   end

   // per-phase actions
   always_comb begin
      dig_acc  = 1'b0;
      dec_step = 1'b0;
      exp_step = 1'b0;
      neg_set  = 1'b0;
      if (has_ch) begin
         case (phase_ff)
            PH_INT:      dig_acc = is_dig;
            PH_FRAC: begin
               dig_acc  = is_dig;
               dec_step = is_dig;
            end
            PH_EXP_SIGN: begin
               neg_set  = (req_ch == CH_MINUS);
               exp_step = is_dig;
            end
            PH_EXP_DIG:  exp_step = is_dig;
            default:     dig_acc = 1'b0;
         endcase
      end
   end

   always_comb begin
      exp_v = (EXPV_W'(exp_ff) << 3) + (EXPV_W'(exp_ff) << 1) + EXPV_W'(dval);
      dec_nx = (dec_step && dec_ff < EXPD_W'(EXP_SAT)) ? dec_ff + EXPD_W'(1) : dec_ff;
      if (!exp_step) exp_nx = exp_ff;
      else if (exp_v > EXPV_W'(EXP_SAT)) exp_nx = EXPD_W'(EXP_SAT);
      else exp_nx = exp_v[EXPD_W-1:0];
      neg_nx = neg_ff || neg_set;

      if (neg_nx) esum = -$signed({2'b00, exp_nx}) - $signed({2'b00, dec_nx});
      else esum = $signed({2'b00, exp_nx}) - $signed({2'b00, dec_nx});

      // clamp to the step budget of the scaling loop
      if (esum > ESUM_HI) scale = ESUM_HI[SCALE_W-1:0];
      else if (esum < ESUM_LO) scale = ESUM_LO[SCALE_W-1:0];
      else scale = esum[SCALE_W-1:0];

      if (!accept) begin
         dec_in = dec_ff;
         exp_in = exp_ff;
         neg_in = neg_ff;
      end else if (finish) begin
         dec_in = '0;
         exp_in = '0;
         neg_in = 1'b0;
      end else begin
         dec_in = dec_nx;
         exp_in = exp_nx;
         neg_in = neg_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_INT;
         dec_ff   <= '0;
         exp_ff   <= '0;
         neg_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         dec_ff   <= dec_in;
         exp_ff   <= exp_in;
         neg_ff   <= neg_in;
      end
   end

   assign req_stall          = q_status.full;
   assign q_push             = accept && (dig_acc || finish);
   assign q_entry.has_digit  = dig_acc;
   assign q_entry.has_finish = finish;
   assign q_entry.digit      = dval;
   assign q_entry.scale      = scale;

endmodule

FILE: rtl/core/dttd_back.sv
// Arithmetic back end: binary64 accumulate, decimal scaling, rounding and result register.
// Depends on dttd_pkg for widths, state codes, the 0.1 significand and digit tables.
module dttd_back import dttd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  q_entry_type  q_head,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [63:0]  rsp_value_bits
);

   back_state_type st_ff, st_in, ret_ff, ret_in;
   logic [63:0]    acc_ff, acc_in;
   logic [3:0]     digit_ff, digit_in;
   logic           fin_ff, fin_in;
   logic signed [SCALE_W-1:0] steps_ff, steps_in;
   logic [W_W-1:0]     w_ff, w_in;
   logic signed [BEXP_W-1:0] bexp_ff, bexp_in;
   logic           stk_ff, stk_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [MOP_W-1:0]   mop_ff, mop_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    rsp_bits_ff, rsp_bits_in;

   logic [10:0]    a_ef, a_e;
   logic [52:0]    a_m;
   logic           a_inf, a_zero, out_free, mulp_last, scale_skip;
   logic [56:0]    m10;
   logic [W_W-1:0] w_m10, w_add, w_mulp;
   logic signed [BEXP_W-1:0] a_es, bexp_m10, bexp_add, bexp_mulp, sd, be;
   logic [W_W+3:0] z_acc, d_sh, z_sum;
   logic           stk_add;
   logic [PROD_W-1:0] prod_nx;
   logic           n_right, n_left, n_left8, norm_done;
   logic [52:0]    mant, mant_f;
   logic [53:0]    mr;
   logic           rnd_up;
   logic [63:0]    rnd_bits;

   // unpack the accumulator
   assign a_ef   = acc_ff[62:52];
   assign a_e    = (a_ef == 11'd0) ? 11'd1 : a_ef;
   assign a_m    = {a_ef != 11'd0, acc_ff[51:0]};
   assign a_inf  = (a_ef == 11'h7FF);
   assign a_zero = (acc_ff[62:0] == 63'd0);
   assign a_es   = $signed({2'b00, a_e});

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign mulp_last  = (cnt_ff == CNT_W'(MULP_ITERS - 1));
   assign scale_skip = (steps_ff == '0) || a_inf || a_zero;

   // times ten: exact 57-bit product, top lands near bit 114
   assign m10      = (57'(a_m) << 3) + (57'(a_m) << 1);
   assign w_m10    = {m10, 59'd0};
   assign bexp_m10 = a_es + BEXP_W'(4);

   // plus digit: align the digit to the accumulator frame, low nibble feeds sticky
   assign z_acc    = {4'd0, a_m, 63'd0};
   assign sd       = BEXP_W'(1138) - a_es;
   assign d_sh     = (W_W+4)'(digit_ff) << sd[6:0];
   assign z_sum    = (sd < 0) ? z_acc : z_acc + d_sh;
   assign stk_add  = (|z_sum[3:0]) || ((sd < 0) && (digit_ff != 4'd0));
   assign w_add    = z_sum[W_W+3:4];
   assign bexp_add = a_es + BEXP_W'(4);

   // times 0.1: radix-16 shift-add over the accumulator significand
   assign prod_nx   = {prod_ff[PROD_W-5:0], 4'd0} + PROD_W'(tenth_multiple(mop_ff[MOP_W-1:MOP_W-4]));
   assign w_mulp    = {prod_nx[105:0], 10'd0};
   assign bexp_mulp = a_es - BEXP_W'(3);

   // normalize one step per cycle
   assign n_right   = (bexp_ff < BEXP_W'(1));
   assign n_left    = !n_right && !w_ff[W_W-1] && (bexp_ff > BEXP_W'(1));
   assign n_left8   = n_left && (w_ff[W_W-1:W_W-8] == 8'd0) && (bexp_ff > BEXP_W'(8));
   assign norm_done = !n_right && !n_left;

   // round to nearest even and pack
   always_comb begin
      mant   = w_ff[W_W-1:W_W-53];
      rnd_up = w_ff[W_W-54] && ((|w_ff[W_W-55:0]) || stk_ff || mant[0]);
      mr     = {1'b0, mant} + 54'(rnd_up);
      if (mr[53]) begin
         mant_f = mr[53:1];
         be     = bexp_ff + BEXP_W'(1);
      end else begin
         mant_f = mr[52:0];
         be     = bexp_ff;
      end
      if (be >= BEXP_W'(2047)) rnd_bits = POS_INF;
      else rnd_bits = {1'b0, mant_f[52] ? be[10:0] : 11'd0, mant_f[51:0]};
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_IDLE:  if (q_status.valid) st_in = q_head.has_digit ? BK_MUL10 : BK_SCALE;
         BK_MUL10: st_in = (a_inf || a_zero) ? BK_ADD : BK_NORM;
         BK_ADD: begin
            if (a_inf || a_zero) st_in = fin_ff ? BK_SCALE : BK_IDLE;
            else st_in = BK_NORM;
         end
         BK_SCALE: begin
            if (scale_skip) st_in = BK_EMIT;
            else if (steps_ff > 0) st_in = BK_NORM;
            else st_in = BK_MULP;
         end
         BK_MULP:  if (mulp_last) st_in = BK_NORM;
         BK_NORM:  if (norm_done) st_in = ret_ff;
         BK_EMIT:  if (out_free) st_in = BK_IDLE;
         default:  st_in = BK_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      acc_in       = acc_ff;
      digit_in     = digit_ff;
      fin_in       = fin_ff;
      steps_in     = steps_ff;
      w_in         = w_ff;
      bexp_in      = bexp_ff;
      stk_in       = stk_ff;
      ret_in       = ret_ff;
      prod_in      = prod_ff;
      mop_in       = mop_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_bits_in  = rsp_bits_ff;
      case (st_ff)
         BK_IDLE: begin
            if (q_status.valid) begin
               digit_in = q_head.digit;
               fin_in   = q_head.has_finish;
               steps_in = q_head.scale;
            end
         end
         BK_MUL10: begin
            w_in    = w_m10;
            bexp_in = bexp_m10;
            stk_in  = 1'b0;
            ret_in  = BK_ADD;
         end
         BK_ADD: begin
            if (a_zero) acc_in = digit_to_double(digit_ff);
            w_in    = w_add;
            bexp_in = bexp_add;
            stk_in  = stk_add;
            ret_in  = fin_ff ? BK_SCALE : BK_IDLE;
         end
         BK_SCALE: begin
            if (!scale_skip) begin
               if (steps_ff > 0) begin
                  w_in     = w_m10;
                  bexp_in  = bexp_m10;
                  stk_in   = 1'b0;
                  ret_in   = BK_SCALE;
                  steps_in = steps_ff - SCALE_W'(1);
               end else begin
                  prod_in  = '0;
                  mop_in   = MOP_W'(a_m);
                  cnt_in   = '0;
                  steps_in = steps_ff + SCALE_W'(1);
               end
            end
         end
         BK_MULP: begin
            prod_in = prod_nx;
            mop_in  = mop_ff << 4;
            cnt_in  = cnt_ff + CNT_W'(1);
            w_in    = w_mulp;
            bexp_in = bexp_mulp;
            stk_in  = 1'b0;
            ret_in  = BK_SCALE;
         end
         BK_NORM: begin
            if (n_right) begin
               w_in    = w_ff >> 1;
               stk_in  = stk_ff || w_ff[0];
               bexp_in = bexp_ff + BEXP_W'(1);
            end else if (n_left8) begin
               w_in    = w_ff << 8;
               bexp_in = bexp_ff - BEXP_W'(8);
            end else if (n_left) begin
               w_in    = w_ff << 1;
               bexp_in = bexp_ff - BEXP_W'(1);
            end else begin
               acc_in = rnd_bits;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = acc_ff;
               acc_in       = 64'd0;
            end
         end
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BK_IDLE;
         acc_ff       <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      digit_ff    <= digit_in;
      fin_ff      <= fin_in;
      steps_ff    <= steps_in;
      w_ff        <= w_in;
      bexp_ff     <= bexp_in;
      stk_ff      <= stk_in;
      prod_ff     <= prod_in;
      mop_ff      <= mop_in;
      cnt_ff      <= cnt_in;
      rsp_bits_ff <= rsp_bits_in;
   end

   assign q_pop          = (st_ff == BK_IDLE) && q_status.valid;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_bits = rsp_bits_ff;

endmodule

FILE: rtl/core/decimal_text_to_double_unit.sv
// Back end work per digit: x10, normalize, +digit, normalize. End of string: each x10 step
// is a scale pass plus normalize, each x0.1 step a radix-16 shift-add plus normalize; up to
// 1100 steps, skipped once the value is 0 or inf. Throughput: one character per cycle unless
// the 4-entry queue is full; the back end's serial float unit sets the sustained rate. Reset
// is synchronous, active high; no clearing pass is needed.
`include "assert_macros.svh"

// Top level: character front end, command queue, float back end and result register.
// The front end parses each transfer at once; digit and finish work goes through the queue,
// so the next string can stream in while the back end still scales the previous value.
module decimal_text_to_double_unit import dttd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value_bits
);

   q_status_type q_status;
   q_entry_type  q_entry;
   q_entry_type  q_head;
   logic         q_push;
   logic         q_pop;

   // classify characters, hold the phase and exponent counters
   dttd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   // decouple the front from the float unit
   dttd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .status     (q_status),
      .head       (q_head)
   );

   // accumulate, scale, round and drive the result transfer
   dttd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value_bits (rsp_value_bits)
   );

   `ASSERT_RST(a_no_push_full, clock, reset, q_push |-> !q_status.full, "push into full queue")
   `ASSERT_RST(a_pop_valid, clock, reset, q_pop |-> q_status.valid, "pop from empty queue")
   `ASSERT_CLK(a_rsp_reset, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule
